// ----- src/rpeg_pkg.sv -----
package rpeg_pkg;

	// Divider produces a 16-bit turn phase, one quotient bit a cycle
	localparam int unsigned PHASE_BITS = 16;
	localparam int unsigned DIV_CNT_W  = 4;

	// CORDIC internals: 24-bit signed, unit 2^22
	localparam int unsigned CW           = 24;
	localparam int unsigned ATAN_ENTRIES = 24;
	localparam int unsigned ATAN_IDX_W   = 5;
	localparam logic signed [CW-1:0] CORDIC_START = 24'sd2547003;

	// Scaling: radius times trig magnitude, guard of 1/256 pixel, then drop 22 bits
	localparam int unsigned RADIUS_W   = 10;
	localparam int unsigned PROD_W     = RADIUS_W + CW;
	localparam int unsigned FRAC_BITS  = 22;
	localparam logic [PROD_W-1:0] GUARD_BIAS = 34'd16384;
	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 10'd100;

	localparam int unsigned COUNT_W = 7;
	localparam int unsigned COORD_W = 11;
	localparam logic [COORD_W-1:0] COORD_MAX = 11'd1023;

	typedef struct packed {
		logic load;
		logic div_step;
		logic seed;
		logic rot_step;
		logic mul;
		logic fin;
		logic emit;
		logic next;
	} cmd_t;

	typedef struct packed {
		logic div_last;
		logic rot_last;
		logic first;
		logic last_seg;
	} status_t;

	// Arctangent of 2^-i in units of 2^-24 turn
	function automatic logic signed [CW-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
		logic signed [CW-1:0] r;
		begin
			unique case (idx)
				5'd0:    r = 24'sd2097152;
				5'd1:    r = 24'sd1238021;
				5'd2:    r = 24'sd654136;
				5'd3:    r = 24'sd332050;
				5'd4:    r = 24'sd166669;
				5'd5:    r = 24'sd83416;
				5'd6:    r = 24'sd41718;
				5'd7:    r = 24'sd20860;
				5'd8:    r = 24'sd10430;
				5'd9:    r = 24'sd5215;
				5'd10:   r = 24'sd2608;
				5'd11:   r = 24'sd1304;
				5'd12:   r = 24'sd652;
				5'd13:   r = 24'sd326;
				5'd14:   r = 24'sd163;
				5'd15:   r = 24'sd81;
				5'd16:   r = 24'sd41;
				5'd17:   r = 24'sd20;
				5'd18:   r = 24'sd10;
				5'd19:   r = 24'sd5;
				5'd20:   r = 24'sd3;
				5'd21:   r = 24'sd1;
				5'd22:   r = 24'sd1;
				default: r = 24'sd0;
			endcase
			return r;
		end
	endfunction

endpackage

// ----- src/regular_polygon_edge_generator.sv -----
// Regular polygon edge generator. Pulse start with a side count N while busy is low;
// the block then emits N segments outlining a regular polygon of radius circle_radius
// centred at the origin, one segment per result_valid pulse, the final one flagged by
// last_segment. Results are shown for exactly one cycle and cannot be stalled, so the
// receiver must take every result_valid cycle. A side count of zero emits nothing and
// busy stays low; counts above MAX_SIDES are saturated. Each vertex passes through
// the bit-serial phase divider, a seed of the rotator, CORDIC_STEPS rotations on the
// single shared CORDIC unit, and the radius multiply and rounding. The radius is
// written through cfg_valid/cfg_ready/cfg_data while the block is idle.
module regular_polygon_edge_generator #(
	parameter int unsigned MAX_SIDES    = 64,
	parameter int unsigned CORDIC_STEPS = 20
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [rpeg_pkg::COUNT_W-1:0]         side_count,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [rpeg_pkg::RADIUS_W-1:0]        cfg_data,
	output logic                                 result_valid,
	output logic signed [rpeg_pkg::COORD_W-1:0]  x_start,
	output logic signed [rpeg_pkg::COORD_W-1:0]  y_start,
	output logic signed [rpeg_pkg::COORD_W-1:0]  x_end,
	output logic signed [rpeg_pkg::COORD_W-1:0]  y_end,
	output logic                                 last_segment
);

	rpeg_pkg::cmd_t    cmd;
	rpeg_pkg::status_t status;

	// Take a radius write only while idle, so a polygon keeps one radius throughout
	assign cfg_ready = !busy;

	rpeg_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.item_nonzero (side_count != '0),
		.status       (status),
		.cmd          (cmd),
		.busy         (busy),
		.result_valid (result_valid)
	);

	rpeg_dpath #(
		.MAX_SIDES    (MAX_SIDES),
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.side_count (side_count),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_data   (cfg_data),
		.status     (status),
		.x_start    (x_start),
		.y_start    (y_start),
		.x_end      (x_end),
		.y_end      (y_end)
	);

	// Only meaningful while result_valid is high
	assign last_segment = status.last_seg;

`ifndef SYNTHESIS
	a_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result shown while idle");

	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last_segment) |=> !busy)
		else $error("block still busy after last segment");

	a_zero_sides_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && side_count == '0) |=> !busy)
		else $error("zero side count started work");

	a_coord_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (x_start != 11'h400 && y_start != 11'h400 &&
			x_end != 11'h400 && y_end != 11'h400))
		else $error("coordinate outside clamp range");
`endif

endmodule

// ----- src/rpeg_ctrl.sv -----
module rpeg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              item_nonzero,
	input  rpeg_pkg::status_t status,
	output rpeg_pkg::cmd_t    cmd,
	output logic              busy,
	output logic              result_valid
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_DIV  = 7'b0000010,
		ST_SEED = 7'b0000100,
		ST_ROT  = 7'b0001000,
		ST_MUL  = 7'b0010000,
		ST_FIN  = 7'b0100000,
		ST_EMIT = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start && item_nonzero) begin
					cmd.load = 1'b1;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = ST_SEED;
				end
			end
			ST_SEED: begin
				cmd.seed = 1'b1;
				state_d  = ST_ROT;
			end
			ST_ROT: begin
				cmd.rot_step = 1'b1;
				if (status.rot_last) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.fin = 1'b1;
				// first vertex only seeds the start point
				if (status.first) begin
					cmd.next = 1'b1;
					state_d  = ST_DIV;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				if (status.last_seg) begin
					state_d = ST_IDLE;
				end else begin
					cmd.next = 1'b1;
					state_d  = ST_DIV;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign result_valid = (state_q == ST_EMIT);

endmodule

// ----- src/rpeg_dpath.sv -----
module rpeg_dpath #(
	parameter int unsigned MAX_SIDES    = 64,
	parameter int unsigned CORDIC_STEPS = 20
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  rpeg_pkg::cmd_t                       cmd,
	input  logic [rpeg_pkg::COUNT_W-1:0]         side_count,
	input  logic                                 cfg_we,
	input  logic [rpeg_pkg::RADIUS_W-1:0]        cfg_data,
	output rpeg_pkg::status_t                    status,
	output logic signed [rpeg_pkg::COORD_W-1:0]  x_start,
	output logic signed [rpeg_pkg::COORD_W-1:0]  y_start,
	output logic signed [rpeg_pkg::COORD_W-1:0]  x_end,
	output logic signed [rpeg_pkg::COORD_W-1:0]  y_end
);

	localparam int unsigned NW     = rpeg_pkg::COUNT_W;
	localparam int unsigned CW     = rpeg_pkg::CW;
	localparam int unsigned PW     = rpeg_pkg::PROD_W;
	localparam int unsigned OW     = rpeg_pkg::COORD_W;
	localparam int unsigned RW     = rpeg_pkg::RADIUS_W;
	localparam int unsigned QW     = rpeg_pkg::PHASE_BITS;
	localparam int unsigned STEP_W = $clog2(CORDIC_STEPS);

	// Sequencing
	logic [NW-1:0]        n_q, k_q, seg_q, rem_q;
	logic [rpeg_pkg::DIV_CNT_W-1:0] dcnt_q;
	logic                 first_q;
	logic [QW-1:0]        quo_q;
	logic [RW-1:0]        radius_q;

	// CORDIC
	logic signed [CW-1:0] x_q, y_q, z_q;
	logic [1:0]           quad_q;
	logic [STEP_W-1:0]    step_q;

	// Scaling
	logic [PW-1:0]        prodx_q, prody_q;
	logic                 negx_q, negy_q;

	// Segment end points
	logic signed [OW-1:0] sx_q, sy_q, ex_q, ey_q;

	logic [NW-1:0]        n_sat, k_first, k_next;
	logic [NW:0]          rem2;
	logic                 ge;
	logic signed [CW-1:0] dx, dy, atan_v, c_v, s_v;
	logic [CW-1:0]        magc, mags;
	logic signed [OW-1:0] cx_v, cy_v;

	function automatic logic signed [OW-1:0] scale_coord(input logic [PW-1:0] prod,
			input logic neg);
		logic [PW-1:0] biased;
		logic [PW-1:0] p;
		logic [OW-1:0] mag;
		begin
			biased = prod + rpeg_pkg::GUARD_BIAS;
			p      = biased >> rpeg_pkg::FRAC_BITS;
			mag    = (p > PW'(rpeg_pkg::COORD_MAX)) ? rpeg_pkg::COORD_MAX : p[OW-1:0];
			return neg ? -$signed(mag) : $signed(mag);
		end
	endfunction

	assign n_sat   = (side_count > NW'(MAX_SIDES)) ? NW'(MAX_SIDES) : side_count;
	assign k_first = (n_sat == NW'(1)) ? '0 : NW'(1);
	assign k_next  = (k_q + NW'(1) == n_q) ? '0 : k_q + NW'(1);

	// Restoring divide step: phase = k * 2^16 / n
	assign rem2 = {rem_q, 1'b0};
	assign ge   = (rem2 >= {1'b0, n_q});

	assign dx     = y_q >>> step_q;
	assign dy     = x_q >>> step_q;
	assign atan_v = rpeg_pkg::atan_turn(rpeg_pkg::ATAN_IDX_W'(step_q));

	// Quadrant fold
	always_comb begin
		case (quad_q)
			2'd0: begin
				c_v = x_q;
				s_v = y_q;
			end
			2'd1: begin
				c_v = -y_q;
				s_v = x_q;
			end
			2'd2: begin
				c_v = -x_q;
				s_v = -y_q;
			end
			default: begin
				c_v = y_q;
				s_v = -x_q;
			end
		endcase
	end

	assign magc = c_v[CW-1] ? CW'(-c_v) : CW'(c_v);
	assign mags = s_v[CW-1] ? CW'(-s_v) : CW'(s_v);

	assign cx_v = scale_coord(prodx_q, negx_q);
	assign cy_v = scale_coord(prody_q, negy_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q      <= '0;
			k_q      <= '0;
			seg_q    <= '0;
			rem_q    <= '0;
			dcnt_q   <= '0;
			first_q  <= 1'b0;
			step_q   <= '0;
			radius_q <= rpeg_pkg::RADIUS_RESET;
		end else begin
			if (cfg_we) begin
				radius_q <= cfg_data;
			end
			if (cmd.load) begin
				n_q     <= n_sat;
				k_q     <= k_first;
				rem_q   <= k_first;
				dcnt_q  <= '0;
				seg_q   <= '0;
				first_q <= 1'b1;
			end
			if (cmd.next) begin
				k_q    <= k_next;
				rem_q  <= k_next;
				dcnt_q <= '0;
			end
			if (cmd.div_step) begin
				rem_q  <= ge ? NW'(rem2 - {1'b0, n_q}) : rem2[NW-1:0];
				dcnt_q <= dcnt_q + 1'b1;
			end
			if (cmd.seed) begin
				step_q <= '0;
			end
			if (cmd.rot_step) begin
				step_q <= step_q + 1'b1;
			end
			if (cmd.fin) begin
				first_q <= 1'b0;
			end
			if (cmd.emit) begin
				seg_q <= seg_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_step) begin
			quo_q <= {quo_q[QW-2:0], ge};
		end
		if (cmd.seed) begin
			x_q    <= rpeg_pkg::CORDIC_START;
			y_q    <= '0;
			z_q    <= $signed({2'b00, quo_q[QW-3:0], 8'h00});
			quad_q <= quo_q[QW-1:QW-2];
		end
		if (cmd.rot_step) begin
			if (!z_q[CW-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - atan_v;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + atan_v;
			end
		end
		if (cmd.mul) begin
			prodx_q <= PW'(radius_q) * PW'(magc);
			prody_q <= PW'(radius_q) * PW'(mags);
			negx_q  <= c_v[CW-1];
			negy_q  <= s_v[CW-1];
		end
		if (cmd.fin) begin
			ex_q <= cx_v;
			ey_q <= cy_v;
			if (first_q) begin
				sx_q <= cx_v;
				sy_q <= cy_v;
			end
		end
		if (cmd.emit) begin
			sx_q <= ex_q;
			sy_q <= ey_q;
		end
	end

	assign status.div_last = (dcnt_q == rpeg_pkg::DIV_CNT_W'(QW - 1));
	assign status.rot_last = (step_q == STEP_W'(CORDIC_STEPS - 1));
	assign status.first    = first_q;
	assign status.last_seg = (seg_q + NW'(1) == n_q);

	assign x_start = sx_q;
	assign y_start = sy_q;
	assign x_end   = ex_q;
	assign y_end   = ey_q;

endmodule
